/* rtl/snsp_pkg.sv */
// Shared constants, types and helpers of the spread-nearest sample picker.
// No dependencies; used by snsp_ctrl, snsp_dp and the top level.
package snsp_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int MAX_PICKS   = 64;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int PICK_W      = $clog2(MAX_PICKS);
  localparam int CFG_W       = 7;
  localparam int DIV_STEPS   = DATA_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
  localparam int DIST_W      = DATA_W + 1;

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic tgt_load;
    logic scan;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic last_target;
  } sts_t;

  // divisor of the target spacing: clamp(num_picks, 2, MAX_PICKS) - 1
  function automatic logic [PICK_W-1:0] pick_div(input logic [CFG_W-1:0] np);
    logic [CFG_W-1:0] p;
    begin
      if (np < CFG_W'(2)) begin
        p = CFG_W'(2);
      end else if (np > CFG_W'(MAX_PICKS)) begin
        p = CFG_W'(MAX_PICKS);
      end else begin
        p = np;
      end
      pick_div = PICK_W'(p - CFG_W'(1));
    end
  endfunction

endpackage

/* rtl/snsp_ctrl.sv */
// Controller of the spread-nearest sample picker: load, divide, target load, scan, emit.
// Depends on snsp_pkg for the command and status structs.
module snsp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              last_sample,
  input  snsp_pkg::sts_t    sts,
  output snsp_pkg::cmd_t    cmd,
  output logic              busy
);

  typedef enum logic [4:0] {
    ST_LOAD = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_TGT  = 5'b00100,
    ST_SCAN = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t                             state_r, state_nxt;
  logic [snsp_pkg::DIV_CNT_W-1:0]     div_cnt_r, div_cnt_nxt;

  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    cmd         = '0;
    busy        = 1'b1;
    case (state_r)
      ST_LOAD: begin
        busy     = 1'b0;
        cmd.load = start;
        if (start && last_sample) begin
          state_nxt   = ST_DIV;
          div_cnt_nxt = '0;
        end
      end
      ST_DIV: begin
        if (div_cnt_r == '0) begin
          cmd.div_init = 1'b1;
        end else begin
          cmd.div_step = 1'b1;
        end
        if (div_cnt_r == snsp_pkg::DIV_CNT_W'(snsp_pkg::DIV_STEPS)) begin
          state_nxt   = ST_TGT;
          div_cnt_nxt = '0;
        end else begin
          div_cnt_nxt = div_cnt_r + snsp_pkg::DIV_CNT_W'(1);
        end
      end
      ST_TGT: begin
        cmd.tgt_load = 1'b1;
        state_nxt    = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = sts.last_target ? ST_LOAD : ST_TGT;
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

endmodule

/* rtl/snsp_dp.sv */
// Datapath of the spread-nearest sample picker: sample stores, min/max,
// serial span divider, target stepping, nearest scan and result register.
// Depends on snsp_pkg; driven by snsp_ctrl.
module snsp_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  snsp_pkg::cmd_t                    cmd,
  output snsp_pkg::sts_t                    sts,
  input  logic                              cfg_we,
  input  logic [snsp_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic signed [snsp_pkg::DATA_W-1:0] in_momentum,
  input  logic [snsp_pkg::DATA_W-1:0]       in_particle_id,
  output logic                              out_valid,
  output logic [snsp_pkg::ADDR_W-1:0]       out_sample_index,
  output logic [snsp_pkg::DATA_W-1:0]       out_picked_id,
  output logic                              out_last_pick
);

  localparam int DW = snsp_pkg::DATA_W;
  localparam int AW = snsp_pkg::ADDR_W;
  localparam int CW = snsp_pkg::CNT_W;
  localparam int PW = snsp_pkg::PICK_W;
  localparam int XW = snsp_pkg::DIST_W;

  logic [DW-1:0]        mom_mem [snsp_pkg::MAX_SAMPLES];
  logic [DW-1:0]        id_mem  [snsp_pkg::MAX_SAMPLES];

  logic [snsp_pkg::CFG_W-1:0] num_picks_r;
  logic [CW-1:0]        cnt_r;
  logic signed [DW-1:0] min_r, max_r;

  logic [DW-1:0]        dvd_r;
  logic [PW-1:0]        rem_r;
  logic [DW-1:0]        off_r;
  logic [PW-1:0]        frac_r;
  logic [PW-1:0]        n_r;
  logic signed [XW-1:0] target_r;

  logic [CW-1:0]        rd_addr_r;
  logic                 v1_r, v2_r, have_r;
  logic [DW-1:0]        rdata_r;
  logic [AW-1:0]        idx1_r, idx2_r, best_idx_r;
  logic [XW-1:0]        dist_r, best_r;

  logic                 out_valid_r, out_last_r;
  logic [AW-1:0]        out_idx_r;
  logic [DW-1:0]        out_id_r;

  logic [PW-1:0]        dsr;
  logic [PW:0]          dsr_x, div_t, fsum;
  logic                 div_ge, carry, full, issue;
  logic [DW-1:0]        span;
  logic signed [XW:0]   diff;

  assign dsr    = snsp_pkg::pick_div(num_picks_r);
  assign dsr_x  = {1'b0, dsr};
  assign span   = DW'(max_r - min_r);
  assign div_t  = {rem_r, dvd_r[DW-1]};
  assign div_ge = div_t >= dsr_x;
  assign fsum   = {1'b0, frac_r} + {1'b0, rem_r};
  assign carry  = fsum >= dsr_x;
  assign full   = cnt_r == CW'(snsp_pkg::MAX_SAMPLES);
  assign issue  = cmd.scan && (rd_addr_r < cnt_r);
  assign diff   = {{2{rdata_r[DW-1]}}, rdata_r} - {target_r[XW-1], target_r};

  assign sts.scan_done   = (rd_addr_r == cnt_r) && !v1_r && !v2_r;
  assign sts.last_target = n_r == dsr;

  assign out_valid        = out_valid_r;
  assign out_sample_index = out_idx_r;
  assign out_picked_id    = out_id_r;
  assign out_last_pick    = out_last_r;

  // store writes and reads
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      mom_mem[cnt_r[AW-1:0]] <= in_momentum;
      id_mem[cnt_r[AW-1:0]]  <= in_particle_id;
    end
    rdata_r <= mom_mem[rd_addr_r[AW-1:0]];
    if (cmd.emit) begin
      out_id_r <= id_mem[best_idx_r];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_picks_r <= snsp_pkg::CFG_W'(2);
      cnt_r       <= '0;
      min_r       <= {1'b0, {(DW-1){1'b1}}};
      max_r       <= {1'b1, {(DW-1){1'b0}}};
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        num_picks_r <= cfg_wdata;
      end
      if (cmd.load && !full) begin
        cnt_r <= cnt_r + CW'(1);
        if (in_momentum < min_r) begin
          min_r <= in_momentum;
        end
        if (in_momentum > max_r) begin
          max_r <= in_momentum;
        end
      end
      if (cmd.emit && sts.last_target) begin
        cnt_r <= '0;
        min_r <= {1'b0, {(DW-1){1'b1}}};
        max_r <= {1'b1, {(DW-1){1'b0}}};
      end
      v1_r <= issue;
      v2_r <= v1_r;
      if (cmd.tgt_load) begin
        have_r <= 1'b0;
      end else if (v2_r && (!have_r || dist_r < best_r)) begin
        have_r <= 1'b1;
      end
      out_valid_r <= cmd.emit;
    end
  end

  // payload: divider, target stepping, scan pipeline, result
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dvd_r  <= span;
      rem_r  <= '0;
      off_r  <= '0;
      frac_r <= '0;
      n_r    <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[DW-2:0], div_ge};
      rem_r <= div_ge ? PW'(div_t - dsr_x) : div_t[PW-1:0];
    end
    if (cmd.emit) begin
      frac_r <= carry ? PW'(fsum - dsr_x) : fsum[PW-1:0];
      off_r  <= off_r + dvd_r + DW'(carry);
      n_r    <= n_r + PW'(1);
    end
    if (cmd.tgt_load) begin
      target_r  <= {min_r[DW-1], min_r} + {1'b0, off_r};
      rd_addr_r <= '0;
    end else if (issue) begin
      rd_addr_r <= rd_addr_r + CW'(1);
    end
    idx1_r <= rd_addr_r[AW-1:0];
    idx2_r <= idx1_r;
    dist_r <= diff[XW] ? XW'(-diff) : diff[XW-1:0];
    if (v2_r && (!have_r || dist_r < best_r)) begin
      best_r     <= dist_r;
      best_idx_r <= idx2_r;
    end
    if (cmd.emit) begin
      out_idx_r  <= best_idx_r;
      out_last_r <= sts.last_target;
    end
  end

endmodule

/* rtl/spread_nearest_sample_picker.sv */
// Top level of the spread-nearest sample picker: joins snsp_ctrl and snsp_dp.
// Depends on snsp_pkg.
//
//   channel | ports                                              | transfer
//   --------+----------------------------------------------------+---------------------
//   input   | in_momentum, in_particle_id, in_last_sample        | start && !busy
//   result  | out_sample_index, out_picked_id, out_last_pick     | out_valid, one cycle
//   config  | cfg_wdata (num_picks)                              | cfg_we
//
// Samples load one per cycle while busy is low. After the last sample the span is
// divided by a bit-serial divider, then each target takes one pass over the
// sample store through a single read port.
// Synchronous active-low reset clears the set; store contents are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module spread_nearest_sample_picker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [snsp_pkg::DATA_W-1:0]  in_momentum,
  input  logic [snsp_pkg::DATA_W-1:0]         in_particle_id,
  input  logic                                in_last_sample,
  output logic                                out_valid,
  output logic [snsp_pkg::ADDR_W-1:0]         out_sample_index,
  output logic [snsp_pkg::DATA_W-1:0]         out_picked_id,
  output logic                                out_last_pick,
  input  logic                                cfg_we,
  input  logic [snsp_pkg::CFG_W-1:0]          cfg_wdata
);

  snsp_pkg::cmd_t cmd;
  snsp_pkg::sts_t sts;

  snsp_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .last_sample (in_last_sample),
    .sts         (sts),
    .cmd         (cmd),
    .busy        (busy)
  );

  snsp_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_momentum      (in_momentum),
    .in_particle_id   (in_particle_id),
    .out_valid        (out_valid),
    .out_sample_index (out_sample_index),
    .out_picked_id    (out_picked_id),
    .out_last_pick    (out_last_pick)
  );

endmodule
